>>> src/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg - shared types and constants of the knock pattern detector
// Widths, reset values, verdict codes and state encodings.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int MAX_BLOCKS_DEF        = 64;
  localparam int MAX_BLOCK_SAMPLES_DEF = 4096;

  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd15000;

  // shared multiplier operands: 30-bit by 16-bit gives a 46-bit product
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 48;

  localparam int QUIET_W = 3;
  localparam logic [QUIET_W-1:0] GAP_MIN = 3'd3;
  localparam logic [QUIET_W-1:0] GAP_MAX = 3'd4;

  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_FOUND  = 2'd1,
    VERDICT_NOCODE = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SQ,
    C_ACC,
    C_TSQ,
    C_LIM,
    C_CMP,
    C_SCAN,
    C_POST
  } ctl_state_t;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_FIRST,
    SC_FIRST_W,
    SC_LA1,
    SC_LA2,
    SC_LA3,
    SC_GAP,
    SC_GAP_W,
    SC_DONE
  } scan_state_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_status_t;

endpackage

>>> src/kpd_mul.sv
// ----------------------------------------------------------------------------
// kpd_mul - shared multiplier
// One 30x16 unsigned multiplier with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module kpd_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [kpd_pkg::MUL_A_W-1:0] op_a,
  input  logic [kpd_pkg::MUL_B_W-1:0] op_b,
  output logic [kpd_pkg::MUL_P_W-1:0] prod
);
  import kpd_pkg::*;

  logic [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

>>> src/kpd_hist.sv
// ----------------------------------------------------------------------------
// kpd_hist - loud flag history
// One-bit-wide memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module kpd_hist #(
  parameter int DEPTH = kpd_pkg::MAX_BLOCKS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_data
);
  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/kpd_scan.sv
// ----------------------------------------------------------------------------
// kpd_scan - knock code scan sequencer
// Walks the loud history one read at a time looking for three knocks.
// ----------------------------------------------------------------------------
module kpd_scan #(
  parameter int MAX_BLOCKS = kpd_pkg::MAX_BLOCKS_DEF,
  parameter int BLK_W      = $clog2(MAX_BLOCKS + 1),
  parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [BLK_W-1:0]      n_blocks,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic                  rd_data,
  output kpd_pkg::scan_status_t status
);
  import kpd_pkg::*;

  scan_state_t         state_r, state_nxt;
  logic [BLK_W-1:0]    first_r, first_nxt;
  logic [BLK_W-1:0]    k_r, k_nxt;
  logic [BLK_W-1:0]    i_r, i_nxt;
  logic [QUIET_W-1:0]  quiet_r, quiet_nxt;
  logic                stage_r, stage_nxt;
  logic                found_r, found_nxt;
  logic [BLK_W-1:0]    k_p1, k_p2;
  logic                look_ok;

  assign k_p1    = k_r + BLK_W'(1);
  assign k_p2    = k_r + BLK_W'(2);
  assign look_ok = ({1'b0, k_r} + (BLK_W+1)'(2)) < {1'b0, n_blocks};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      found_r <= 1'b0;
      stage_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      stage_r <= stage_nxt;
    end
    first_r <= first_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    quiet_r <= quiet_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    quiet_nxt = quiet_r;
    stage_nxt = stage_r;
    found_nxt = found_r;
    rd_addr   = first_r[IDX_W-1:0];
    status    = '0;

    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          first_nxt = '0;
          state_nxt = SC_FIRST;
        end
      end
      SC_FIRST: begin
        if (first_r >= n_blocks) begin
          found_nxt = 1'b0;
          state_nxt = SC_DONE;
        end else begin
          state_nxt = SC_FIRST_W;
        end
      end
      SC_FIRST_W: begin
        if (rd_data) begin
          k_nxt     = first_r;
          stage_nxt = 1'b0;
          state_nxt = SC_LA1;
        end else begin
          first_nxt = first_r + BLK_W'(1);
          state_nxt = SC_FIRST;
        end
      end
      SC_LA1: begin
        // lookahead for a two-block knock needs both following blocks present
        rd_addr   = k_p1[IDX_W-1:0];
        quiet_nxt = '0;
        if (look_ok) begin
          state_nxt = SC_LA2;
        end else begin
          i_nxt     = k_p1;
          state_nxt = SC_GAP;
        end
      end
      SC_LA2: begin
        rd_addr = k_p2[IDX_W-1:0];
        if (rd_data) begin
          state_nxt = SC_LA3;
        end else begin
          i_nxt     = k_p1;
          state_nxt = SC_GAP;
        end
      end
      SC_LA3: begin
        if (!rd_data) begin
          k_nxt = k_p1;
          i_nxt = k_p2;
        end else begin
          i_nxt = k_p1;
        end
        state_nxt = SC_GAP;
      end
      SC_GAP: begin
        rd_addr = i_r[IDX_W-1:0];
        if (i_r >= n_blocks) begin
          first_nxt = first_r + BLK_W'(1);
          state_nxt = SC_FIRST;
        end else begin
          state_nxt = SC_GAP_W;
        end
      end
      SC_GAP_W: begin
        if (rd_data) begin
          if (quiet_r == GAP_MIN || quiet_r == GAP_MAX) begin
            if (stage_r) begin
              found_nxt = 1'b1;
              state_nxt = SC_DONE;
            end else begin
              stage_nxt = 1'b1;
              k_nxt     = i_r;
              state_nxt = SC_LA1;
            end
          end else begin
            first_nxt = first_r + BLK_W'(1);
            state_nxt = SC_FIRST;
          end
        end else if (quiet_r == GAP_MAX) begin
          // gap already too long: drop this candidate
          first_nxt = first_r + BLK_W'(1);
          state_nxt = SC_FIRST;
        end else begin
          quiet_nxt = quiet_r + QUIET_W'(1);
          i_nxt     = i_r + BLK_W'(1);
          state_nxt = SC_GAP;
        end
      end
      SC_DONE: begin
        status.done  = 1'b1;
        status.found = found_r;
        state_nxt    = SC_IDLE;
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

endmodule

>>> src/knock_pattern_detector_unit.sv
// ----------------------------------------------------------------------------
// knock_pattern_detector_unit - knock code detector on blocked audio
// Energy per block, loud history, and a scan for a three-knock code.
// ----------------------------------------------------------------------------
// Each input beat is one signed sample; in_block_end marks a block's last
// sample. A plain sample passes accept, square and accumulate steps before
// in_ready returns; the shared multiplier is used once for it. A block-end
// sample then adds the loudness test (threshold squared, times the sample
// count, compare) and the history scan, one read at a time on the single
// read port, before in_ready returns. Each block end yields one out beat:
// verdict 0 while undecided, 1 when the code is found, 2 when MAX_BLOCKS
// blocks passed without it. After a verdict of 1 or 2 samples are still
// taken but dropped, and no further out beat appears until reset. A
// finished verdict waits in the output register while new samples are
// accepted. cfg_loud_threshold is written through its own always-ready
// channel; the user must write it only while the block is idle, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module knock_pattern_detector_unit #(
  parameter int MAX_BLOCKS        = kpd_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_BLOCK_SAMPLES = kpd_pkg::MAX_BLOCK_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [kpd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_block_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_verdict,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kpd_pkg::THR_W-1:0]          cfg_loud_threshold
);
  import kpd_pkg::*;

  localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);

  ctl_state_t          state_r, state_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic                halted_r, halted_nxt;
  logic [BLK_W-1:0]    blocks_r, blocks_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] mag_r, mag_nxt;
  logic                end_r, end_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  verdict_t            verdict_r, verdict_nxt;

  logic                mul_en;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic                hist_we;
  logic                hist_wd;
  logic [IDX_W-1:0]    hist_ra;
  logic                hist_rd;
  logic                scan_start;
  scan_status_t        scan_st;
  logic [SUM_W:0]      sum_add;
  logic [SAMPLE_W-1:0] in_mag;

  // magnitude of the signed sample; the most negative value maps to 32768
  assign in_mag  = in_sample[SAMPLE_W-1] ? SAMPLE_W'(~in_sample + 1'b1) : in_sample;
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(mul_p);

  kpd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  kpd_hist #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (blocks_r[IDX_W-1:0]),
    .wr_data (hist_wd),
    .rd_addr (hist_ra),
    .rd_data (hist_rd)
  );

  kpd_scan #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLK_W      (BLK_W),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .n_blocks (blocks_r),
    .rd_addr  (hist_ra),
    .rd_data  (hist_rd),
    .status   (scan_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      thr_r       <= THR_RESET;
      halted_r    <= 1'b0;
      blocks_r    <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      halted_r    <= halted_nxt;
      blocks_r    <= blocks_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r     <= mag_nxt;
    end_r     <= end_nxt;
    verdict_r <= verdict_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    halted_nxt    = halted_r;
    blocks_nxt    = blocks_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    end_nxt       = end_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    hist_we       = 1'b0;
    hist_wd       = 1'b0;
    scan_start    = 1'b0;

    if (cfg_valid) begin
      thr_nxt = cfg_loud_threshold;
    end

    // retire the pending verdict beat
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      C_IDLE: begin
        // once halted, take samples and drop them
        if (in_valid && !halted_r) begin
          mag_nxt   = in_mag;
          end_nxt   = in_block_end;
          state_nxt = C_SQ;
        end
      end
      C_SQ: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(mag_r);
        mul_b     = MUL_B_W'(mag_r);
        state_nxt = C_ACC;
      end
      C_ACC: begin
        // samples beyond the block limit are ignored, the count holds
        if (cnt_r < CNT_W'(MAX_BLOCK_SAMPLES)) begin
          sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = end_r ? C_TSQ : C_IDLE;
      end
      C_TSQ: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(thr_r);
        mul_b     = MUL_B_W'(thr_r);
        state_nxt = C_LIM;
      end
      C_LIM: begin
        // threshold squared is below 2^30, so its low bits carry it all
        mul_en    = 1'b1;
        mul_a     = mul_p[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(cnt_r);
        state_nxt = C_CMP;
      end
      C_CMP: begin
        hist_we    = 1'b1;
        hist_wd    = sum_r > SUM_W'(mul_p);
        blocks_nxt = blocks_r + BLK_W'(1);
        sum_nxt    = '0;
        cnt_nxt    = '0;
        scan_start = 1'b1;
        state_nxt  = C_SCAN;
      end
      C_SCAN: begin
        if (scan_st.done) begin
          found_nxt = scan_st.found;
          state_nxt = C_POST;
        end
      end
      C_POST: begin
        // hold the verdict until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            verdict_nxt = VERDICT_FOUND;
            halted_nxt  = 1'b1;
          end else if (blocks_r >= BLK_W'(MAX_BLOCKS)) begin
            verdict_nxt = VERDICT_NOCODE;
            halted_nxt  = 1'b1;
          end else begin
            verdict_nxt = VERDICT_NONE;
          end
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  assign in_ready    = (state_r == C_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  // once halted with no beat pending, no new verdict beat may appear
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !out_valid_r |=> !out_valid_r)
    else $error("verdict beat after halt");

  // the scan reports only while the controller waits for it
  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_st.done |-> state_r == C_SCAN)
    else $error("scan done outside scan wait");

  // the history never grows past its depth
  a_blocks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_CMP |-> blocks_r < BLK_W'(MAX_BLOCKS))
    else $error("history overflow");

  // a verdict of found or no code always leaves the block halted
  a_verdict_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r != VERDICT_NONE |-> halted_r)
    else $error("final verdict without halt");

endmodule
